>>> src/sed_pkg.sv
package sed_pkg;

    // saturation width of the per-string byte counter
    localparam int COUNT_BITS = 16;
    // width that holds both the counter and the 16-bit reported count
    localparam int COUNT_EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // characters that steer the parser
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HEX_BYTE  = 8'h78;
    localparam logic [7:0] CH_HEX_WORD  = 8'h75;

    // hex digit runs
    localparam logic [2:0] DIGITS_BYTE = 3'd2;
    localparam logic [2:0] DIGITS_WORD = 3'd4;

    // one result of the parser for the item just taken
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] count;
    } t_result;

endpackage

>>> src/sed_parse.sv
module sed_parse
    import sed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    output t_result    o_res
);

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_DROP = 2'd3
    } t_mode;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_mode                 r_mode, n_mode;
    logic [2:0]            r_left, n_left;
    logic [3:0]            r_high, n_high;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  at_end;
    logic [4:0]            hex_val;
    logic [8:0]            esc_val;
    logic [COUNT_EXT_BITS-1:0] count_ext;
    logic [15:0]           count_rep;

    // hex digit value, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] v;
        v = 5'd16;
        if (ch >= "0" && ch <= "9") v = 5'(ch - "0");
        else if (ch >= "a" && ch <= "f") v = 5'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F") v = 5'(ch - "A" + 8'd10);
        return v;
    endfunction

    // simple escapes, bit 8 set when the character is one of them
    function automatic logic [8:0] esc_map(input logic [7:0] ch);
        logic [8:0] v;
        v = 9'd0;
        unique case (ch)
            "a":          v = {1'b1, 8'h07};
            "b":          v = {1'b1, 8'h08};
            "f":          v = {1'b1, 8'h0C};
            "n":          v = {1'b1, 8'h0A};
            "r":          v = {1'b1, 8'h0D};
            "t":          v = {1'b1, 8'h09};
            "v":          v = {1'b1, 8'h0B};
            "0":          v = {1'b1, 8'h00};
            CH_BACKSLASH: v = {1'b1, CH_BACKSLASH};
            8'h22:        v = {1'b1, 8'h22};
            default:      v = 9'd0;
        endcase
        return v;
    endfunction

    assign at_end  = (i_char == CH_NUL);
    assign hex_val = hex_value(i_char);
    assign esc_val = esc_map(i_char);

    // reported count clips at 16 bits
    assign count_ext = COUNT_EXT_BITS'(r_count);
    assign count_rep = (count_ext > COUNT_EXT_BITS'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];

    // next state and result for one character
    always_comb begin
        n_mode  = r_mode;
        n_left  = r_left;
        n_high  = r_high;
        n_count = r_count;
        o_res   = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, count: 16'd0};
        unique case (r_mode)
            MODE_TEXT: begin
                if (at_end) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_END;
                    o_res.count = count_rep;
                    n_left      = 3'd0;
                    n_high      = 4'd0;
                    n_count     = '0;
                end else if (i_char == CH_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_char;
                    if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_TEXT;
                if (esc_val[8]) begin
                    o_res.valid = 1'b1;
                    o_res.data  = esc_val[7:0];
                    if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
                end else if (i_char == CH_HEX_BYTE) begin
                    n_mode = MODE_HEX;
                    n_left = DIGITS_BYTE;
                end else if (i_char == CH_HEX_WORD) begin
                    n_mode = MODE_HEX;
                    n_left = DIGITS_WORD;
                end else begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERR;
                    if (at_end) begin
                        n_left  = 3'd0;
                        n_high  = 4'd0;
                        n_count = '0;
                    end else begin
                        n_mode = MODE_DROP;
                    end
                end
            end
            MODE_HEX: begin
                if (at_end || hex_val[4] || r_left == 3'd0) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERR;
                    if (at_end) begin
                        n_mode  = MODE_TEXT;
                        n_left  = 3'd0;
                        n_high  = 4'd0;
                        n_count = '0;
                    end else begin
                        n_mode = MODE_DROP;
                    end
                end else if (!r_left[0]) begin
                    n_high = hex_val[3:0];
                    n_left = r_left - 3'd1;
                end else begin
                    n_left      = r_left - 3'd1;
                    if (r_left == 3'd1) n_mode = MODE_TEXT;
                    o_res.valid = 1'b1;
                    o_res.data  = {r_high, hex_val[3:0]};
                    if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
                end
            end
            MODE_DROP: begin
                // silent until the terminator
                if (at_end) begin
                    n_mode  = MODE_TEXT;
                    n_left  = 3'd0;
                    n_high  = 4'd0;
                    n_count = '0;
                end
            end
            default: n_mode = MODE_TEXT;
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TEXT;
            r_left  <= 3'd0;
            r_high  <= 4'd0;
            r_count <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_left  <= n_left;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

endmodule

>>> src/string_escape_decoder.sv
// String escape decoder: takes one source character per item, a zero byte
// ending the string, and gives at most one result per character: a decoded
// data byte, an end-of-string result with the decoded byte count (saturating),
// or an error for a bad escape, a bad hex digit or an escape cut short. After
// an error characters are dropped without result until the terminator. The
// parser updates its state in the cycle the character is accepted and the
// result lands in an output register, so the result appears in the cycle
// after acceptance and a character can be accepted every cycle. The input
// is stalled only while that output register holds a result and the output
// side is stalling.
module string_escape_decoder
    import sed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_byte_count
);

    logic        take;
    t_result     res;
    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_data;
    logic [15:0] r_count;

    // input item taken when the output register is free or being emptied
    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    sed_parse u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_char (i_in_char),
        .o_res  (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_kind  <= res.kind;
            r_data  <= res.data;
            r_count <= res.count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_data;
    assign o_byte_count = r_count;

endmodule

>>> src/sed_checker.sv
module sed_checker
    import sed_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_char,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [15:0] o_byte_count
);

    // only data results carry a byte
    a_byte_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_out_byte == 8'd0)
        else $error("non-data result carries a byte");

    // only end results carry a count
    a_count_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_END |-> o_byte_count == 16'd0)
        else $error("non-end result carries a count");

    // input held back only while a result waits
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no waiting result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_out_byte) && $stable(o_byte_count))
        else $error("stalled result changed");

    // an idle input side creates no new result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_valid && !o_out_valid |=> !o_out_valid)
        else $error("result without an input item");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);
